FILE: src/dwr_pkg.sv
// ----------------------------------------------------------------------------
// dwr_pkg: shared widths, register indexes and reset values
// Common definitions for the draw-without-replacement block and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwr_pkg;

    // Default pool size
    localparam int POOL_DEPTH_DEF = 64;

    // Field widths
    localparam int LOW_W      = 16;
    localparam int COUNT_W    = 7;
    localparam int WORD_W     = 31;
    localparam int VALUE_W    = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 2'd1;

    // Register reset values
    localparam logic [LOW_W-1:0]   RANGE_LOW_RST   = 16'sd0;
    localparam logic [COUNT_W-1:0] RANGE_COUNT_RST = 7'd6;

endpackage

FILE: src/dwr_mod.sv
// ----------------------------------------------------------------------------
// dwr_mod: iterative modulo unit
// Restoring division, one quotient bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwr_mod
#(
    parameter int REM_W = 7
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dwr_pkg::WORD_W-1:0]  dividend,
    input  logic [REM_W-1:0]            divisor,
    output logic                        done,
    output logic [REM_W-1:0]            remainder
);
    import dwr_pkg::*;

    localparam int STEP_W = $clog2(WORD_W);

    logic                busy_reg,    busy_next;
    logic                done_reg,    done_next;
    logic [STEP_W-1:0]   step_reg,    step_next;
    logic [WORD_W-1:0]   shift_reg,   shift_next;
    logic [REM_W-1:0]    rem_reg,     rem_next;
    logic [REM_W-1:0]    divisor_reg, divisor_next;
    logic [REM_W:0]      partial;

    assign partial = {rem_reg, shift_reg[WORD_W-1]};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            shift_next   = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            // partial stays below twice the divisor, so one subtract restores it
            if (partial >= {1'b0, divisor_reg})
            begin
                rem_next = REM_W'(partial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = partial[REM_W-1:0];
            end
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            step_next  = step_reg + 1'b1;
            if (step_reg == STEP_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: src/dwr_pool.sv
// ----------------------------------------------------------------------------
// dwr_pool: offset pool memory
// One write port and two registered read ports over the live offsets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwr_pool
#(
    parameter int DEPTH = 64
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [$clog2(DEPTH)-1:0]   wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
    output logic [$clog2(DEPTH)-1:0]   rd_data_a,
    output logic [$clog2(DEPTH)-1:0]   rd_data_b
);
    import dwr_pkg::*;

    localparam int OW = $clog2(DEPTH);

    logic [OW-1:0] pool_mem [DEPTH];
    logic [OW-1:0] rd_data_a_reg;
    logic [OW-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pool_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a_reg <= pool_mem[rd_addr_a];
            rd_data_b_reg <= pool_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

FILE: src/draw_without_replacement.sv
// ----------------------------------------------------------------------------
// draw_without_replacement: shuffled draws of range_low .. range_low+count-1, count capped at the pool size
// Sequence: an accepted request passes through CHECK, the 31-step modulo unit
// (MOD), one pool read (READ) and one write-back (WRITE) to the done strobe; an
// empty pool answers straight from CHECK. The first draw after reset also
// fills the pool first (FILL).
// Requests: a new request is taken only once the block is idle again; no result stall.
// Reset: asynchronous; the pool is refilled on the first draw after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module draw_without_replacement
#(
    parameter int POOL_DEPTH = dwr_pkg::POOL_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dwr_pkg::WORD_W-1:0]          random_word,
    output logic                                done,
    output logic signed [dwr_pkg::VALUE_W-1:0]  drawn_value,
    output logic                                exhausted,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dwr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dwr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dwr_pkg::*;

    localparam int RW = $clog2(POOL_DEPTH + 1);
    localparam int OW = $clog2(POOL_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;

    logic [2:0]          state_reg,       state_next;
    logic                filled_reg,      filled_next;
    logic [RW-1:0]       remaining_reg,   remaining_next;
    logic [RW-1:0]       fill_idx_reg,    fill_idx_next;
    logic [WORD_W-1:0]   word_reg,        word_next;
    logic [OW-1:0]       pick_reg,        pick_next;
    logic [LOW_W-1:0]    range_low_reg;
    logic [COUNT_W-1:0]  range_count_reg;
    logic                done_reg,        done_next;
    logic [VALUE_W-1:0]  drawn_value_reg, drawn_value_next;
    logic                exhausted_reg,   exhausted_next;

    logic [RW-1:0]       fill_count;
    logic                mod_start;
    logic                mod_done;
    logic [RW-1:0]       mod_rem;
    logic                wr_en;
    logic [OW-1:0]       wr_addr;
    logic [OW-1:0]       wr_data;
    logic                rd_en;
    logic [OW-1:0]       rd_addr_a;
    logic [OW-1:0]       rd_addr_b;
    logic [OW-1:0]       rd_data_a;
    logic [OW-1:0]       rd_data_b;

    dwr_mod #(
        .REM_W (RW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (word_reg),
        .divisor   (remaining_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    dwr_pool #(
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // saturate the configured count to the pool size
    always_comb
    begin
        if (32'(range_count_reg) > 32'(POOL_DEPTH))
        begin
            fill_count = RW'(POOL_DEPTH);
        end
        else
        begin
            fill_count = RW'(range_count_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        filled_next      = filled_reg;
        remaining_next   = remaining_reg;
        fill_idx_next    = fill_idx_reg;
        word_next        = word_reg;
        pick_next        = pick_reg;
        done_next        = 1'b0;
        drawn_value_next = drawn_value_reg;
        exhausted_next   = exhausted_reg;
        mod_start        = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = OW'(fill_idx_reg);
        wr_data          = OW'(fill_idx_reg);
        rd_en            = 1'b0;
        rd_addr_a        = pick_reg;
        rd_addr_b        = OW'(remaining_reg - 1'b1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    word_next = random_word;
                    if (!filled_reg)
                    begin
                        remaining_next = fill_count;
                        fill_idx_next  = '0;
                        state_next     = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FILL:
            begin
                if (fill_idx_reg == remaining_reg)
                begin
                    filled_next = 1'b1;
                    state_next  = ST_CHECK;
                end
                else
                begin
                    wr_en         = 1'b1;
                    fill_idx_next = fill_idx_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (remaining_reg == '0)
                begin
                    done_next        = 1'b1;
                    drawn_value_next = '0;
                    exhausted_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    pick_next  = OW'(mod_rem);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // fetch the picked entry and the last live entry together
                rd_en      = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // move the last live entry into the picked slot
                wr_en            = 1'b1;
                wr_addr          = pick_reg;
                wr_data          = rd_data_b;
                drawn_value_next = {range_low_reg[LOW_W-1], range_low_reg}
                                   + VALUE_W'(rd_data_a);
                exhausted_next   = 1'b0;
                done_next        = 1'b1;
                remaining_next   = remaining_reg - 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            filled_reg      <= 1'b0;
            remaining_reg   <= '0;
            fill_idx_reg    <= '0;
            done_reg        <= 1'b0;
            drawn_value_reg <= '0;
            exhausted_reg   <= 1'b0;
            range_low_reg   <= RANGE_LOW_RST;
            range_count_reg <= RANGE_COUNT_RST;
        end
        else
        begin
            state_reg       <= state_next;
            filled_reg      <= filled_next;
            remaining_reg   <= remaining_next;
            fill_idx_reg    <= fill_idx_next;
            done_reg        <= done_next;
            drawn_value_reg <= drawn_value_next;
            exhausted_reg   <= exhausted_next;
            if (cfg_valid && cfg_ready)
            begin
                // drop writes to unknown indexes
                unique case (cfg_index)
                    REG_RANGE_LOW:   range_low_reg   <= cfg_data[LOW_W-1:0];
                    REG_RANGE_COUNT: range_count_reg <= cfg_data[COUNT_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        pick_reg <= pick_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign drawn_value = drawn_value_reg;
    assign exhausted   = exhausted_reg;

endmodule

FILE: src/dwr_checker.sv
// ----------------------------------------------------------------------------
// dwr_checker: port-level checks for the draw block
// Watches request and result timing on the top level's ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwr_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [dwr_pkg::WORD_W-1:0]          random_word,
    input logic                                done,
    input logic signed [dwr_pkg::VALUE_W-1:0]  drawn_value,
    input logic                                exhausted,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [dwr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [dwr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dwr_pkg::*;

    // an accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // a result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // a result appears as the block returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // no result straight after a request is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result one cycle after request");

    // an exhausted answer carries a zero value
    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && exhausted) |-> (drawn_value == '0))
        else $error("exhausted result with non-zero value");

endmodule

bind draw_without_replacement dwr_checker u_dwr_checker (.*);
